>>> rtl/rgb_to_hsl_converter_core_defines.svh
// Assertion macros for the RTL
`ifndef RGB_TO_HSL_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RTHSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RTHSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rthsl_pkg.sv
`timescale 1ns / 1ps
package rthsl_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned SUM_W      = 9;
	localparam int unsigned N_W        = 11;
	localparam int unsigned NUM_W      = 24;
	localparam int unsigned DVS_W      = 8;
	localparam int unsigned HUE_W      = 15;
	localparam int unsigned SAT_W      = 17;
	localparam int unsigned DIV_STEPS  = 4;
	localparam int unsigned DIV_STAGES = NUM_W / DIV_STEPS;

	localparam logic [NUM_W-1:0] HUE_FULL = 24'd23040;
	localparam logic [SUM_W-1:0] HALF_SUM = 9'd255;
	localparam logic [SUM_W-1:0] FULL_SUM = 9'd510;

	// hue offset of the sector in units of 60 degrees, halved
	typedef enum logic [1:0] {
		HOFS_0   = 2'd0,
		HOFS_120 = 2'd1,
		HOFS_240 = 2'd2,
		HOFS_360 = 2'd3
	} hofs_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DVS_W-1:0] dvs;
	} div_op_t;

	typedef struct packed {
		div_op_t          hue;
		div_op_t          sat;
		logic             grey;
		logic [SUM_W-1:0] sum;
	} div_req_t;

	typedef struct packed {
		logic [NUM_W-1:0] hue_quo;
		logic [NUM_W-1:0] sat_quo;
		logic             grey;
		logic [SUM_W-1:0] sum;
	} div_rsp_t;

endpackage

>>> rtl/rthsl_div.sv
`timescale 1ns / 1ps
module rthsl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rthsl_pkg::div_req_t in_req,
	output logic                out_valid,
	input  logic                out_ready,
	output rthsl_pkg::div_rsp_t out_rsp
);
	import rthsl_pkg::*;

	localparam int unsigned LAST = DIV_STAGES - 1;

	typedef struct packed {
		logic [DVS_W-1:0] rem;
		logic [NUM_W-1:0] work;
		logic [DVS_W-1:0] dvs;
	} lane_t;

	lane_t            hue_s    [DIV_STAGES];
	lane_t            sat_s    [DIV_STAGES];
	logic             grey_s   [DIV_STAGES];
	logic [SUM_W-1:0] sum_s    [DIV_STAGES];
	lane_t            hue_prev [DIV_STAGES];
	lane_t            sat_prev [DIV_STAGES];
	logic             grey_prev[DIV_STAGES];
	logic [SUM_W-1:0] sum_prev [DIV_STAGES];
	lane_t            hue_nxt  [DIV_STAGES];
	lane_t            sat_nxt  [DIV_STAGES];
	logic [DIV_STAGES-1:0] v_s;
	logic [DIV_STAGES-1:0] v_prev;
	logic [DIV_STAGES-1:0] en;

	// restoring division, DIV_STEPS (4) quotient bits per stage
	function automatic lane_t div_steps(input lane_t a);
		lane_t          r;
		logic [DVS_W:0] t;
		r = a;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {r.rem, r.work[NUM_W-1]};
			if (t >= {1'b0, r.dvs}) begin
				r.rem  = DVS_W'(t - {1'b0, r.dvs});
				r.work = {r.work[NUM_W-2:0], 1'b1};
			end else begin
				r.rem  = t[DVS_W-1:0];
				r.work = {r.work[NUM_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	assign v_prev = {v_s[DIV_STAGES-2:0], in_valid};

	always_comb begin
		hue_prev[0]  = '{rem: '0, work: in_req.hue.num, dvs: in_req.hue.dvs};
		sat_prev[0]  = '{rem: '0, work: in_req.sat.num, dvs: in_req.sat.dvs};
		grey_prev[0] = in_req.grey;
		sum_prev[0]  = in_req.sum;
		for (int st = 1; st < DIV_STAGES; st++) begin
			hue_prev[st]  = hue_s[st-1];
			sat_prev[st]  = sat_s[st-1];
			grey_prev[st] = grey_s[st-1];
			sum_prev[st]  = sum_s[st-1];
		end
		for (int st = 0; st < DIV_STAGES; st++) begin
			hue_nxt[st] = div_steps(hue_prev[st]);
			sat_nxt[st] = div_steps(sat_prev[st]);
		end
	end

	// a stage moves when empty or when the one after it moves
	always_comb begin
		en[LAST] = !v_s[LAST] || out_ready;
		for (int st = DIV_STAGES - 2; st >= 0; st--) begin
			en[st] = !v_s[st] || en[st+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int st = 0; st < DIV_STAGES; st++) begin
				if (en[st]) begin
					v_s[st] <= v_prev[st];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int st = 0; st < DIV_STAGES; st++) begin
			if (en[st] && v_prev[st]) begin
				hue_s[st]  <= hue_nxt[st];
				sat_s[st]  <= sat_nxt[st];
				grey_s[st] <= grey_prev[st];
				sum_s[st]  <= sum_prev[st];
			end
		end
	end

	assign in_ready        = en[0];
	assign out_valid       = v_s[LAST];
	assign out_rsp.hue_quo = hue_s[LAST].work;
	assign out_rsp.sat_quo = sat_s[LAST].work;
	assign out_rsp.grey    = grey_s[LAST];
	assign out_rsp.sum     = sum_s[LAST];

endmodule

>>> rtl/rgb_to_hsl_converter_core.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (lsb up)                          | tuser | tlast
// s_axis  | in  | red[7:0] green[15:8] blue[23:16]                | -     | -
// m_axis  | out | hue_q[14:0] saturation_q[31:15] lightness[40:32] | -     | -
//
// One pixel per clock sustained while m_axis_tready is high.
// Hue and saturation use two 24-step restoring dividers, 4 quotient bits per stage.
// arst_n clears all valid bits; payload registers are not reset.
// Each stage holds on stall and fills bubbles, so s_axis_tready stays high
// while any stage downstream is empty.
`include "rgb_to_hsl_converter_core_defines.svh"
module rgb_to_hsl_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red, green, blue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // hue_q, saturation_q, lightness_sum, zero pad
);
	import rthsl_pkg::*;

	logic [PIX_W-1:0] red, green, blue;
	logic             ge_rg, ge_rb, ge_gb, red_max, green_max;

	logic                    v_s1, v_s2, v_s3;
	logic                    en1, en2, en3;
	logic [PIX_W-1:0]        mx_s1, mn_s1;
	hofs_t                   hofs_s1;
	logic signed [PIX_W:0]   diff_s1;
	logic [PIX_W-1:0]        d_s2;
	logic [SUM_W-1:0]        sum_s2;
	logic [N_W-1:0]          n_s2;
	div_req_t                req_s3;

	logic [PIX_W-1:0]        mx_c, mn_c;
	hofs_t                   hofs_c;
	logic signed [PIX_W:0]   diff_c;
	logic [PIX_W-1:0]        d_c;
	logic [N_W-1:0]          kd_c;
	logic signed [N_W:0]     n_c;
	logic [HUE_W-1:0]        n15_c;
	logic [SUM_W-1:0]        den_w;

	logic                    div_ready, div_valid, out_en;
	div_rsp_t                rsp;
	logic [NUM_W-1:0]        hue_wrap;

	logic                    out_valid_q;
	logic [HUE_W-1:0]        hue_q;
	logic [SAT_W-1:0]        sat_q;
	logic [SUM_W-1:0]        sum_q;

	assign red   = s_axis_tdata[7:0];
	assign green = s_axis_tdata[15:8];
	assign blue  = s_axis_tdata[23:16];

	// stage 1: max, min and hue sector
	always_comb begin
		ge_rg     = red >= green;
		ge_rb     = red >= blue;
		ge_gb     = green >= blue;
		red_max   = ge_rg && ge_rb;
		green_max = !red_max && ge_gb;
		if (red_max) begin
			mx_c   = red;
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
			hofs_c = ge_gb ? HOFS_0 : HOFS_360;
		end else if (green_max) begin
			mx_c   = green;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
			hofs_c = HOFS_120;
		end else begin
			mx_c   = blue;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
			hofs_c = HOFS_240;
		end
		if (red <= green && red <= blue) begin
			mn_c = red;
		end else if (green <= blue) begin
			mn_c = green;
		end else begin
			mn_c = blue;
		end
	end

	// stage 2: spread, sum and hue numerator in sixths
	always_comb begin
		d_c = mx_s1 - mn_s1;
		case (hofs_s1)
			HOFS_0:   kd_c = '0;
			HOFS_120: kd_c = {2'b0, d_c, 1'b0};
			HOFS_240: kd_c = {1'b0, d_c, 2'b0};
			HOFS_360: kd_c = {1'b0, d_c, 2'b0} + {2'b0, d_c, 1'b0};
			default:  kd_c = '0;
		endcase
		n_c = $signed({1'b0, kd_c}) + $signed({{(N_W-PIX_W){diff_s1[PIX_W]}}, diff_s1});
	end

	// stage 3: divider operands
	always_comb begin
		n15_c = {n_s2, 4'b0} - {4'b0, n_s2};
		den_w = (sum_s2 <= HALF_SUM) ? sum_s2 : (FULL_SUM - sum_s2);
	end

	assign en3           = !v_s3 || div_ready;
	assign en2           = !v_s2 || en3;
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid) begin
			mx_s1   <= mx_c;
			mn_s1   <= mn_c;
			hofs_s1 <= hofs_c;
			diff_s1 <= diff_c;
		end
		if (en2 && v_s1) begin
			d_s2   <= d_c;
			sum_s2 <= {1'b0, mx_s1} + {1'b0, mn_s1};
			n_s2   <= n_c[N_W-1:0];
		end
		if (en3 && v_s2) begin
			req_s3.hue.num <= {1'b0, n15_c, 8'b0};
			req_s3.hue.dvs <= d_s2;
			req_s3.sat.num <= {d_s2, 16'b0};
			req_s3.sat.dvs <= den_w[DVS_W-1:0];
			req_s3.grey    <= d_s2 == '0;
			req_s3.sum     <= sum_s2;
		end
	end

	rthsl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_ready),
		.in_req    (req_s3),
		.out_valid (div_valid),
		.out_ready (out_en),
		.out_rsp   (rsp)
	);

	// output register
	assign out_en   = !out_valid_q || m_axis_tready;
	assign hue_wrap = (rsp.hue_quo >= HUE_FULL) ? (rsp.hue_quo - HUE_FULL) : rsp.hue_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && div_valid) begin
			hue_q <= rsp.grey ? '0 : hue_wrap[HUE_W-1:0];
			sat_q <= rsp.grey ? '0 : rsp.sat_quo[SAT_W-1:0];
			sum_q <= rsp.sum;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, sum_q, sat_q, hue_q};

	`RTHSL_ASSERT_NOW(a_stall_full, !s_axis_tready, v_s1 && v_s2 && v_s3, "input stalled with a bubble in front stages")
	`RTHSL_ASSERT_NOW(a_hue_range, m_axis_tvalid, m_axis_tdata[14:0] < 15'd23040, "hue out of range")
	`RTHSL_ASSERT_NOW(a_sat_range, m_axis_tvalid, m_axis_tdata[31:15] <= 17'd65536, "saturation out of range")
	`RTHSL_ASSERT_NOW(a_black, m_axis_tvalid && m_axis_tdata[40:32] == 9'd0, m_axis_tdata[31:0] == 32'd0, "black pixel with nonzero hue or saturation")
	`RTHSL_ASSERT_NEXT(a_out_load, div_valid && out_en, m_axis_tvalid, "divider result not taken into output register")

endmodule
